@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port checker of the remap core.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define LUD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression must never be true.
`define LUD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

@@ hw/rtl/lud_pkg.sv @@
// Shared constants, widths, register codes and the sideband type of the remap core.
// Depends on nothing; every module of the core imports it.
`timescale 1ns / 1ps

package lud_pkg;

	// Frame geometry.
	localparam int IMG_WIDTH  = 2048;
	localparam int IMG_HEIGHT = 1024;
	localparam int COL_W      = $clog2(IMG_WIDTH);
	localparam int ROW_W      = $clog2(IMG_HEIGHT);
	localparam int PIX_W      = 8;

	// Register widths and fixed point.
	localparam int FOC_W  = 24;
	localparam int CEN_W  = 21;
	localparam int COEF_W = 24;
	localparam int FRAC   = 20;
	localparam int IDX_W  = 3;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_FOCAL_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_FOCAL_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd3;
	localparam logic [IDX_W-1:0] REG_RADIAL_K1 = 3'd4;
	localparam logic [IDX_W-1:0] REG_RADIAL_K2 = 3'd5;
	localparam logic [IDX_W-1:0] REG_TANG_P1 = 3'd6;
	localparam logic [IDX_W-1:0] REG_TANG_P2 = 3'd7;

	// Register reset values.
	localparam logic [FOC_W-1:0] FOCAL_X_RST = 24'd883098;
	localparam logic [FOC_W-1:0] FOCAL_Y_RST = 24'd883105;
	localparam logic [CEN_W-1:0] CENTER_X_RST = 21'd171111;
	localparam logic [CEN_W-1:0] CENTER_Y_RST = 21'd120999;
	localparam logic signed [COEF_W-1:0] RADIAL_K1_RST = -24'sd94686;
	localparam logic signed [COEF_W-1:0] RADIAL_K2_RST = 24'sd776890;
	localparam logic signed [COEF_W-1:0] TANG_P1_RST = -24'sd1258;
	localparam logic signed [COEF_W-1:0] TANG_P2_RST = 24'sd1363;

	// Divider: signed offset, its magnitude, quotient bits and numerator bits below the point.
	localparam int DX_W    = CEN_W + 2;
	localparam int MAG_W   = DX_W - 1;
	localparam int DIV_Q_W = 24;
	localparam int LOW_W   = DIV_Q_W - FRAC;
	localparam logic [DIV_Q_W-1:0] XN_MAX = DIV_Q_W'(1) << (DIV_Q_W - 1);

	// Widths of the polynomial terms (signed).
	localparam int XN_W  = DIV_Q_W + 1;
	localparam int SQ_W  = 28;
	localparam int R2_W  = 29;
	localparam int T_W   = 30;
	localparam int R4_W  = 36;
	localparam int K1R_W = 32;
	localparam int TP_W  = 33;
	localparam int TAN_W = 35;
	localparam int K2R_W = 39;
	localparam int F_W   = 40;
	localparam int FH_W  = F_W - FRAC;
	localparam int PA_W  = 44;
	localparam int PB_W  = 26;
	localparam int SUM_W = 46;
	localparam int XD_W  = 33;
	localparam int S_W   = 37;
	localparam logic signed [SUM_W-1:0] XD_LIM = SUM_W'(64'sd1 <<< 31);

	// Inside bounds of the source point, 1/256 pixel.
	localparam logic signed [S_W-1:0] SX_HI = S_W'((IMG_WIDTH - 1) * 256);
	localparam logic signed [S_W-1:0] SY_HI = S_W'((IMG_HEIGHT - 1) * 256);

	// Frame store banks, split by column and row parity.
	localparam int BANK_N  = 4;
	localparam int BANK_AW = COL_W + ROW_W - 2;
	localparam int BANK_D  = 1 << BANK_AW;
	localparam int W_W     = 17;
	localparam int PROD_W  = W_W + PIX_W;
	localparam int ACC_W   = PROD_W + 2;

	// Latency of each unit and of the whole core.
	localparam int DIV_LAT  = DIV_Q_W + 2;
	localparam int WARP_LAT = 7;
	localparam int SMP_LAT  = 4;
	localparam int LUD_LAT  = DIV_LAT + WARP_LAT + SMP_LAT;

	// Item fields that travel alongside the arithmetic.
	typedef struct packed {
		logic vld;
		logic remap;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] pix;
	} side_t;

endpackage

@@ hw/rtl/lens_undistort_bilinear_remap_core.sv @@
// Top level of the lens undistortion remap core: registers, divider, warp and sampler.
// Depends on lud_pkg, lud_div, lud_warp and lud_sample.
//
//   channel   signals                           transfer when
//   command   start, busy, cmd, col, row,       start high and busy low
//             pixel_in
//   result    done, pixel_out, inside_res       done high, one cycle only
//   config    wr_en, wr_idx, wr_data            wr_en high
//
// One item enters per cycle; busy stays low. A remap passes through the divider,
// one bit per stage, then the polynomial pipeline and the store read and blend.
// A load gives no result and writes the store at the same stage where remaps read,
// so order is kept. Reset clears the valid bits and restores the registers; the store
// is not cleared.
`timescale 1ns / 1ps

module lens_undistort_bilinear_remap_core import lud_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cmd,
	input  logic [COL_W-1:0] col,
	input  logic [ROW_W-1:0] row,
	input  logic [PIX_W-1:0] pixel_in,
	output logic done,
	output logic [PIX_W-1:0] pixel_out,
	output logic inside_res,
	input  logic wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [FOC_W-1:0] wr_data
);

	logic [FOC_W-1:0] focal_x_q, focal_y_q;
	logic [CEN_W-1:0] center_x_q, center_y_q;
	logic signed [COEF_W-1:0] k1_q, k2_q, p1_q, p2_q;
	logic [FOC_W-1:0] fx, fy;
	side_t side_in, side_div, side_warp;
	logic signed [XN_W-1:0] xn, yn;
	logic signed [S_W-1:0] sx, sy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= FOCAL_X_RST;
			focal_y_q <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			k1_q <= RADIAL_K1_RST;
			k2_q <= RADIAL_K2_RST;
			p1_q <= TANG_P1_RST;
			p2_q <= TANG_P2_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_FOCAL_X: focal_x_q <= wr_data;
				REG_FOCAL_Y: focal_y_q <= wr_data;
				REG_CENTER_X: center_x_q <= wr_data[CEN_W-1:0];
				REG_CENTER_Y: center_y_q <= wr_data[CEN_W-1:0];
				REG_RADIAL_K1: k1_q <= wr_data;
				REG_RADIAL_K2: k2_q <= wr_data;
				REG_TANG_P1: p1_q <= wr_data;
				REG_TANG_P2: p2_q <= wr_data;
			endcase
		end
	end

	// A zero focal length acts as one.
	assign fx = (focal_x_q == '0) ? FOC_W'(1) : focal_x_q;
	assign fy = (focal_y_q == '0) ? FOC_W'(1) : focal_y_q;

	assign busy = 1'b0;

	always_comb begin
		side_in.vld = start && !busy;
		side_in.remap = cmd;
		side_in.col = col;
		side_in.row = row;
		side_in.pix = pixel_in;
	end

	lud_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.side_in(side_in),
		.fx(fx),
		.fy(fy),
		.cx(center_x_q),
		.cy(center_y_q),
		.side_out(side_div),
		.xn(xn),
		.yn(yn)
	);

	lud_warp u_warp (
		.clk(clk),
		.arst_n(arst_n),
		.side_in(side_div),
		.xn(xn),
		.yn(yn),
		.fx(fx),
		.fy(fy),
		.cx(center_x_q),
		.cy(center_y_q),
		.k1(k1_q),
		.k2(k2_q),
		.p1(p1_q),
		.p2(p2_q),
		.side_out(side_warp),
		.sx(sx),
		.sy(sy)
	);

	lud_sample u_sample (
		.clk(clk),
		.arst_n(arst_n),
		.side_in(side_warp),
		.sx(sx),
		.sy(sy),
		.done(done),
		.pixel_out(pixel_out),
		.inside_res(inside_res)
	);

endmodule

@@ hw/rtl/lud_div.sv @@
// Pipelined normalizing divider: offset from the optical center times 2^20 over focal length.
// Depends on lud_pkg; one quotient bit per stage for both axes, clamped to +-2^23.
`timescale 1ns / 1ps

module lud_div import lud_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  side_t side_in,
	input  logic [FOC_W-1:0] fx,
	input  logic [FOC_W-1:0] fy,
	input  logic [CEN_W-1:0] cx,
	input  logic [CEN_W-1:0] cy,
	output side_t side_out,
	output logic signed [XN_W-1:0] xn,
	output logic signed [XN_W-1:0] yn
);

	side_t side_q [0:DIV_LAT-1];
	logic [FOC_W-1:0] rem_q [0:DIV_Q_W][0:1];
	logic [DIV_Q_W-1:0] quo_q [0:DIV_Q_W][0:1];
	logic [LOW_W-1:0] low_q [0:DIV_Q_W][0:1];
	logic neg_q [0:DIV_Q_W][0:1];
	logic sat_q [0:DIV_Q_W][0:1];
	logic signed [XN_W-1:0] xn_q [0:1];

	logic [FOC_W-1:0] foc [0:1];
	logic [DX_W-1:0] num [0:1];
	logic [DX_W-1:0] cen [0:1];
	logic [DX_W-1:0] dx [0:1];
	logic [DX_W-1:0] mag [0:1];

	assign foc[0] = fx;
	assign foc[1] = fy;
	assign num[0] = {{(DX_W - COL_W - 8){1'b0}}, side_in.col, 8'b0};
	assign num[1] = {{(DX_W - ROW_W - 8){1'b0}}, side_in.row, 8'b0};
	assign cen[0] = {{(DX_W - CEN_W){1'b0}}, cx};
	assign cen[1] = {{(DX_W - CEN_W){1'b0}}, cy};

	// Signed offset and its magnitude.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			dx[l] = num[l] - cen[l];
			mag[l] = dx[l][DX_W-1] ? (~dx[l] + DX_W'(1)) : dx[l];
		end
	end

	// Entry stage: a quotient of 2^24 or more saturates at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q[0] <= '0;
		end else begin
			side_q[0] <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			rem_q[0][l] <= {{(FOC_W - MAG_W + LOW_W){1'b0}}, mag[l][MAG_W-1:LOW_W]};
			low_q[0][l] <= mag[l][LOW_W-1:0];
			quo_q[0][l] <= '0;
			neg_q[0][l] <= dx[l][DX_W-1];
			sat_q[0][l] <= {{(FOC_W - MAG_W + LOW_W){1'b0}}, mag[l][MAG_W-1:LOW_W]}
				>= foc[l];
		end
	end

	// Restoring steps, most significant quotient bit first.
	for (genvar s = 1; s <= DIV_Q_W; s++) begin : g_step
		logic [FOC_W:0] trial [0:1];
		logic [FOC_W:0] diff [0:1];
		logic ge [0:1];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {rem_q[s-1][l], low_q[s-1][l][LOW_W-1]};
				diff[l] = trial[l] - {1'b0, foc[l]};
				ge[l] = trial[l] >= {1'b0, foc[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_q[s] <= '0;
			end else begin
				side_q[s] <= side_q[s-1];
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < 2; l++) begin
				rem_q[s][l] <= ge[l] ? diff[l][FOC_W-1:0] : trial[l][FOC_W-1:0];
				quo_q[s][l] <= {quo_q[s-1][l][DIV_Q_W-2:0], ge[l]};
				low_q[s][l] <= {low_q[s-1][l][LOW_W-2:0], 1'b0};
				neg_q[s][l] <= neg_q[s-1][l];
				sat_q[s][l] <= sat_q[s-1][l];
			end
		end
	end

	// Clamp to 2^23 and apply the sign (truncation toward zero).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q[DIV_LAT-1] <= '0;
		end else begin
			side_q[DIV_LAT-1] <= side_q[DIV_Q_W];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (sat_q[DIV_Q_W][l] || quo_q[DIV_Q_W][l] > XN_MAX) begin
				xn_q[l] <= neg_q[DIV_Q_W][l] ? -$signed({1'b0, XN_MAX})
					: $signed({1'b0, XN_MAX});
			end else begin
				xn_q[l] <= neg_q[DIV_Q_W][l] ? -$signed({1'b0, quo_q[DIV_Q_W][l]})
					: $signed({1'b0, quo_q[DIV_Q_W][l]});
			end
		end
	end

	assign side_out = side_q[DIV_LAT-1];
	assign xn = xn_q[0];
	assign yn = xn_q[1];

endmodule

@@ hw/rtl/lud_warp.sv @@
// Distortion polynomial pipeline: radial and tangential terms, then back to pixel units.
// Depends on lud_pkg; at most one multiplier level per stage, seven stages.
`timescale 1ns / 1ps

module lud_warp import lud_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  side_t side_in,
	input  logic signed [XN_W-1:0] xn,
	input  logic signed [XN_W-1:0] yn,
	input  logic [FOC_W-1:0] fx,
	input  logic [FOC_W-1:0] fy,
	input  logic [CEN_W-1:0] cx,
	input  logic [CEN_W-1:0] cy,
	input  logic signed [COEF_W-1:0] k1,
	input  logic signed [COEF_W-1:0] k2,
	input  logic signed [COEF_W-1:0] p1,
	input  logic signed [COEF_W-1:0] p2,
	output side_t side_out,
	output logic signed [S_W-1:0] sx,
	output logic signed [S_W-1:0] sy
);

	side_t side_s [1:WARP_LAT];

	logic signed [XN_W-1:0] xn_s1, yn_s1, xn_s2, yn_s2, xn_s3, yn_s3, xn_s4, yn_s4;
	logic signed [SQ_W-1:0] xx_s1, yy_s1, xy_s1, xy_s2;
	logic signed [R2_W-1:0] r2_s2;
	logic signed [T_W-1:0] tx_s2, ty_s2;
	logic signed [R4_W-1:0] r4_s3;
	logic signed [K1R_W-1:0] k1r_s3;
	logic signed [TAN_W-1:0] tanx_s3, tany_s3, tanx_s4, tany_s4, tanx_s5, tany_s5;
	logic signed [F_W-1:0] f_s4;
	logic signed [PA_W-1:0] pax_s5, pay_s5;
	logic signed [PB_W-1:0] pbx_s5, pby_s5;
	logic signed [XD_W-1:0] xd_s6, yd_s6;
	logic signed [S_W-1:0] sx_s7, sy_s7;

	// Stage 1 products.
	logic signed [2*XN_W-1:0] m_xx, m_yy, m_xy;
	// Stage 3 products.
	logic signed [2*R2_W-1:0] m_r4;
	logic signed [COEF_W+R2_W-1:0] m_k1;
	logic signed [COEF_W+SQ_W-1:0] m_p1xy, m_p2xy;
	logic signed [COEF_W+T_W-1:0] m_p2tx, m_p1ty;
	// Stage 4 product.
	logic signed [COEF_W+R4_W-1:0] m_k2;
	// Stage 5 products.
	logic signed [XN_W+FH_W-1:0] m_pax, m_pay;
	logic signed [XN_W+FRAC:0] m_pbx, m_pby;
	logic signed [FH_W-1:0] fh;
	logic signed [FRAC:0] fl;
	// Stage 6 sums.
	logic signed [SUM_W-1:0] sumx, sumy;
	// Stage 7 products.
	logic signed [XD_W+FOC_W:0] m_sx, m_sy;

	// Sideband travels with the arithmetic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= WARP_LAT; i++) begin
				side_s[i] <= '0;
			end
		end else begin
			side_s[1] <= side_in;
			for (int i = 2; i <= WARP_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Squares and cross term; a floor shift keeps the bits above the point.
	always_comb begin
		m_xx = xn * xn;
		m_yy = yn * yn;
		m_xy = xn * yn;
	end

	always_ff @(posedge clk) begin
		xx_s1 <= m_xx[FRAC+SQ_W-1:FRAC];
		yy_s1 <= m_yy[FRAC+SQ_W-1:FRAC];
		xy_s1 <= m_xy[FRAC+SQ_W-1:FRAC];
		xn_s1 <= xn;
		yn_s1 <= yn;
	end

	// Squared radius and the tangential operands.
	always_ff @(posedge clk) begin
		r2_s2 <= R2_W'(xx_s1) + R2_W'(yy_s1);
		tx_s2 <= T_W'(xx_s1) + T_W'(yy_s1) + (T_W'(xx_s1) <<< 1);
		ty_s2 <= T_W'(xx_s1) + T_W'(yy_s1) + (T_W'(yy_s1) <<< 1);
		xy_s2 <= xy_s1;
		xn_s2 <= xn_s1;
		yn_s2 <= yn_s1;
	end

	// Fourth power, first radial term and both tangential sums.
	always_comb begin
		m_r4 = r2_s2 * r2_s2;
		m_k1 = k1 * r2_s2;
		m_p1xy = p1 * xy_s2;
		m_p2xy = p2 * xy_s2;
		m_p2tx = p2 * tx_s2;
		m_p1ty = p1 * ty_s2;
	end

	always_ff @(posedge clk) begin
		r4_s3 <= m_r4[FRAC+R4_W-1:FRAC];
		k1r_s3 <= m_k1[FRAC+K1R_W-1:FRAC];
		// Doubling then shifting by 20 is a shift by 19.
		tanx_s3 <= TAN_W'($signed(m_p1xy[FRAC-1+K1R_W-1:FRAC-1]))
			+ TAN_W'($signed(m_p2tx[FRAC+TP_W-1:FRAC]));
		tany_s3 <= TAN_W'($signed(m_p2xy[FRAC-1+K1R_W-1:FRAC-1]))
			+ TAN_W'($signed(m_p1ty[FRAC+TP_W-1:FRAC]));
		xn_s3 <= xn_s2;
		yn_s3 <= yn_s2;
	end

	// Radial factor.
	always_comb begin
		m_k2 = k2 * r4_s3;
	end

	always_ff @(posedge clk) begin
		f_s4 <= (F_W'(1) <<< FRAC) + F_W'(k1r_s3)
			+ F_W'($signed(m_k2[FRAC+K2R_W-1:FRAC]));
		tanx_s4 <= tanx_s3;
		tany_s4 <= tany_s3;
		xn_s4 <= xn_s3;
		yn_s4 <= yn_s3;
	end

	// Coordinate times the radial factor, split at the binary point.
	always_comb begin
		fh = f_s4[F_W-1:FRAC];
		fl = $signed({1'b0, f_s4[FRAC-1:0]});
		m_pax = xn_s4 * fh;
		m_pay = yn_s4 * fh;
		m_pbx = xn_s4 * fl;
		m_pby = yn_s4 * fl;
	end

	always_ff @(posedge clk) begin
		pax_s5 <= m_pax[PA_W-1:0];
		pay_s5 <= m_pay[PA_W-1:0];
		pbx_s5 <= m_pbx[FRAC+PB_W-1:FRAC];
		pby_s5 <= m_pby[FRAC+PB_W-1:FRAC];
		tanx_s5 <= tanx_s4;
		tany_s5 <= tany_s4;
	end

	// Distorted coordinate, clamped to +-2^31.
	always_comb begin
		sumx = SUM_W'(pax_s5) + SUM_W'(pbx_s5) + SUM_W'(tanx_s5);
		sumy = SUM_W'(pay_s5) + SUM_W'(pby_s5) + SUM_W'(tany_s5);
	end

	always_ff @(posedge clk) begin
		if (sumx > XD_LIM) begin
			xd_s6 <= XD_W'(XD_LIM);
		end else if (sumx < -XD_LIM) begin
			xd_s6 <= XD_W'(-XD_LIM);
		end else begin
			xd_s6 <= sumx[XD_W-1:0];
		end
		if (sumy > XD_LIM) begin
			yd_s6 <= XD_W'(XD_LIM);
		end else if (sumy < -XD_LIM) begin
			yd_s6 <= XD_W'(-XD_LIM);
		end else begin
			yd_s6 <= sumy[XD_W-1:0];
		end
	end

	// Back to 1/256 pixel units around the optical center.
	always_comb begin
		m_sx = xd_s6 * $signed({1'b0, fx});
		m_sy = yd_s6 * $signed({1'b0, fy});
	end

	always_ff @(posedge clk) begin
		sx_s7 <= m_sx[FRAC+S_W-1:FRAC] + $signed({{(S_W - CEN_W){1'b0}}, cx});
		sy_s7 <= m_sy[FRAC+S_W-1:FRAC] + $signed({{(S_W - CEN_W){1'b0}}, cy});
	end

	assign side_out = side_s[WARP_LAT];
	assign sx = sx_s7;
	assign sy = sy_s7;

endmodule

@@ hw/rtl/lud_sample.sv @@
// Banked frame store and bilinear sampler; loads write in order with remap reads.
// Depends on lud_pkg; four banks by column and row parity give four reads per cycle.
`timescale 1ns / 1ps

module lud_sample import lud_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  side_t side_in,
	input  logic signed [S_W-1:0] sx,
	input  logic signed [S_W-1:0] sy,
	output logic done,
	output logic [PIX_W-1:0] pixel_out,
	output logic inside_res
);

	logic rvld_s1, rvld_s2, rvld_s3, done_q;
	logic inside_s1, inside_s2, inside_s3, inside_q;
	logic [7:0] ax_s1, ay_s1;
	logic ix0_s1, iy0_s1, ix0_s2, iy0_s2;
	logic we_s1 [0:BANK_N-1];
	logic [BANK_AW-1:0] addr_s1 [0:BANK_N-1];
	logic [PIX_W-1:0] wdata_s1;
	logic [PIX_W-1:0] rd_s2 [0:BANK_N-1];
	logic [W_W-1:0] w_s2 [0:BANK_N-1];
	logic [PROD_W-1:0] prod_s3 [0:BANK_N-1];
	logic [PIX_W-1:0] pixel_q;

	logic src_in, in_frame;
	logic [COL_W-1:0] ix;
	logic [ROW_W-1:0] iy;
	logic [COL_W:0] ix_p1;
	logic [ROW_W:0] iy_p1;
	logic [COL_W-2:0] csel [0:1];
	logic [ROW_W-2:0] rsel [0:1];
	logic [8:0] ox, oy;
	logic [PIX_W-1:0] nb [0:BANK_N-1];
	logic [ACC_W-1:0] acc;

	// Inside test and neighbor addresses. Bank index is {row parity, column parity}.
	always_comb begin
		src_in = sx > $signed(S_W'(0)) && sx < SX_HI
			&& sy > $signed(S_W'(0)) && sy < SY_HI;
		in_frame = ({1'b0, side_in.col} < (COL_W+1)'(IMG_WIDTH))
			&& ({1'b0, side_in.row} < (ROW_W+1)'(IMG_HEIGHT));
		ix = sx[COL_W+7:8];
		iy = sy[ROW_W+7:8];
		ix_p1 = {1'b0, ix} + (COL_W+1)'(1);
		iy_p1 = {1'b0, iy} + (ROW_W+1)'(1);
		csel[0] = ix_p1[COL_W-1:1];
		csel[1] = ix[COL_W-1:1];
		rsel[0] = iy_p1[ROW_W-1:1];
		rsel[1] = iy[ROW_W-1:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			for (int b = 0; b < BANK_N; b++) begin
				we_s1[b] <= 1'b0;
			end
		end else begin
			rvld_s1 <= side_in.vld && side_in.remap;
			for (int b = 0; b < BANK_N; b++) begin
				we_s1[b] <= side_in.vld && !side_in.remap && in_frame
					&& {side_in.row[0], side_in.col[0]} == 2'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		inside_s1 <= src_in;
		ax_s1 <= sx[7:0];
		ay_s1 <= sy[7:0];
		ix0_s1 <= ix[0];
		iy0_s1 <= iy[0];
		wdata_s1 <= side_in.pix;
		for (int b = 0; b < BANK_N; b++) begin
			addr_s1[b] <= side_in.remap ? {rsel[b/2], csel[b%2]}
				: {side_in.row[ROW_W-1:1], side_in.col[COL_W-1:1]};
		end
	end

	// Frame store banks: one write or one read per bank per item.
	for (genvar b = 0; b < BANK_N; b++) begin : g_bank
		logic [PIX_W-1:0] mem [0:BANK_D-1];

		always_ff @(posedge clk) begin
			if (we_s1[b]) begin
				mem[addr_s1[b]] <= wdata_s1;
			end
			rd_s2[b] <= mem[addr_s1[b]];
		end
	end

	// Bilinear weights, computed beside the store read.
	always_comb begin
		ox = 9'd256 - {1'b0, ax_s1};
		oy = 9'd256 - {1'b0, ay_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s2 <= 1'b0;
		end else begin
			rvld_s2 <= rvld_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s2[0] <= W_W'(ox * oy);
		w_s2[1] <= W_W'({1'b0, ax_s1} * oy);
		w_s2[2] <= W_W'(ox * {1'b0, ay_s1});
		w_s2[3] <= W_W'({1'b0, ax_s1} * {1'b0, ay_s1});
		inside_s2 <= inside_s1;
		ix0_s2 <= ix0_s1;
		iy0_s2 <= iy0_s1;
	end

	// Route banks to neighbors by the parity of the top-left sample, then weight.
	always_comb begin
		nb[0] = rd_s2[{iy0_s2, ix0_s2}];
		nb[1] = rd_s2[{iy0_s2, ~ix0_s2}];
		nb[2] = rd_s2[{~iy0_s2, ix0_s2}];
		nb[3] = rd_s2[{~iy0_s2, ~ix0_s2}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s3 <= 1'b0;
		end else begin
			rvld_s3 <= rvld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < BANK_N; b++) begin
			prod_s3[b] <= PROD_W'(w_s2[b] * nb[b]);
		end
		inside_s3 <= inside_s2;
	end

	// Sum, truncate, zero an outside result, and present the result for one cycle.
	always_comb begin
		acc = ACC_W'(prod_s3[0]) + ACC_W'(prod_s3[1]) + ACC_W'(prod_s3[2])
			+ ACC_W'(prod_s3[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rvld_s3;
		end
	end

	always_ff @(posedge clk) begin
		inside_q <= inside_s3;
		pixel_q <= inside_s3 ? acc[16+PIX_W-1:16] : '0;
	end

	assign done = done_q;
	assign pixel_out = pixel_q;
	assign inside_res = inside_q;

endmodule

@@ hw/rtl/lud_checker.sv @@
// Port-level checks of the remap core, attached to the top level by bind.
// Depends on lud_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lud_checker import lud_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cmd,
	input logic done,
	input logic [PIX_W-1:0] pixel_out,
	input logic inside_res
);

	localparam int CYC_W = $clog2(LUD_LAT + 1);

	logic [CYC_W-1:0] cyc_q;
	logic full;

	// Cycles since reset, so that a lookback never reaches across a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q <= '0;
		end else if (cyc_q != CYC_W'(LUD_LAT)) begin
			cyc_q <= cyc_q + CYC_W'(1);
		end
	end

	assign full = cyc_q == CYC_W'(LUD_LAT);

	`LUD_ASSERT_NEVER(a_never_busy, clk, arst_n, busy, "core refused a command")
	`LUD_ASSERT_IMP(a_remap_answered, clk, arst_n, full && $past(start && !busy && cmd, LUD_LAT), done, "remap transfer gave no result")
	`LUD_ASSERT_IMP(a_result_has_cause, clk, arst_n, done, $past(start && !busy && cmd, LUD_LAT), "result without a remap transfer")
	`LUD_ASSERT_IMP(a_outside_zero, clk, arst_n, done && !inside_res, pixel_out == '0, "outside result is not zero")

endmodule

bind lens_undistort_bilinear_remap_core lud_checker u_lud_checker (.*);
